// ===== src/sqh_pkg.sv =====
// ----------------------------------------------------------------------------
// sqh_pkg
// Shared types and constants for the stack, queue and heap trace checker.
// ----------------------------------------------------------------------------
package sqh_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int ITEM_WIDTH      = 32;

    // Verdict codes given with the result of the last operation.
    typedef enum logic [2:0] {
        V_IMPOSSIBLE = 3'd0,
        V_NOT_SURE   = 3'd1,
        V_STACK      = 3'd2,
        V_QUEUE      = 3'd3,
        V_HEAP       = 3'd4,
        V_OVERFLOW   = 3'd5
    } verdict_t;

    // Per-structure update strobes sent from the control to every cell.
    typedef struct packed {
        logic stack_push;
        logic stack_pop;
        logic fifo_push;
        logic fifo_pop;
        logic heap_push;
        logic heap_pop;
    } sqh_op_t;

endpackage

// ===== src/sqh_if.sv =====
// ----------------------------------------------------------------------------
// sqh_in_if / sqh_out_if
// Valid/ready channels for operations in and verdicts out.
// ----------------------------------------------------------------------------
interface sqh_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] item_value;
    logic               last_op;

    modport source (output valid, cmd, item_value, last_op, input ready);
    modport sink   (input valid, cmd, item_value, last_op, output ready);
endinterface

interface sqh_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       stack_fits;
    logic       queue_fits;
    logic       heap_fits;

    modport source (output valid, verdict, stack_fits, queue_fits, heap_fits, input ready);
    modport sink   (input valid, verdict, stack_fits, queue_fits, heap_fits, output ready);
endinterface

// ===== src/stack_queue_heap_trace_checker_top.sv =====
// Latency: the verdict is registered and appears in the cycle after the last operation is transferred.
// Throughput: one operation per cycle while input is not held off; all cell rows update together.
// Input is held off only while a verdict waits and the sink is not ready.
// Reset (rst_n, asynchronous, active low) empties all rows and revives all three
// structures; cell contents are not cleared, fill counts guard every read.
// ----------------------------------------------------------------------------
// stack_queue_heap_trace_checker_top
// Replays push/pop traces against stack, queue and max priority queue rows.
// ----------------------------------------------------------------------------
module stack_queue_heap_trace_checker_top #(
    parameter int DEPTH       = sqh_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sqh_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sqh_in_if.sink    in_ch,
    sqh_out_if.source out_ch
);
    import sqh_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    sqh_op_t                       op;
    logic signed [VALUE_WIDTH-1:0] key;
    logic [CW-1:0]                 fifo_fill;
    logic [CW-1:0]                 heap_fill;

    logic signed [VALUE_WIDTH-1:0] stack_v [DEPTH+1];
    logic signed [VALUE_WIDTH-1:0] fifo_v  [DEPTH+1];
    logic signed [VALUE_WIDTH-1:0] heap_v  [DEPTH+1];
    logic                          gt_v    [DEPTH];

    // Control and verdict.
    sqh_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .stack_top (stack_v[0]),
        .fifo_top  (fifo_v[0]),
        .heap_top  (heap_v[0]),
        .op        (op),
        .key       (key),
        .fifo_fill (fifo_fill),
        .heap_fill (heap_fill)
    );

    // The slot past the end feeds filler into the last cell.
    assign stack_v[DEPTH] = '0;
    assign fifo_v[DEPTH]  = '0;
    assign heap_v[DEPTH]  = '0;

    // Row of cells; cell zero holds the top, head and maximum.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sqh_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (i)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .key         (key),
            .fifo_fill   (fifo_fill),
            .heap_fill   (heap_fill),
            .left_stack  ((i == 0) ? key : stack_v[(i == 0) ? 0 : i-1]),
            .left_heap   ((i == 0) ? key : heap_v[(i == 0) ? 0 : i-1]),
            .left_gt     ((i == 0) ? 1'b0 : gt_v[(i == 0) ? 0 : i-1]),
            .right_stack (stack_v[i+1]),
            .right_fifo  (fifo_v[i+1]),
            .right_heap  (heap_v[i+1]),
            .stack_val   (stack_v[i]),
            .fifo_val    (fifo_v[i]),
            .heap_val    (heap_v[i]),
            .gt          (gt_v[i])
        );
    end

endmodule

// ===== src/sqh_cell.sv =====
// ----------------------------------------------------------------------------
// sqh_cell
// One slot of the stack, queue and sorted priority queue rows.
// ----------------------------------------------------------------------------
module sqh_cell #(
    parameter int DEPTH       = sqh_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sqh_pkg::VALUE_WIDTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                                clk,
    input  sqh_pkg::sqh_op_t                    op,
    input  logic signed [VALUE_WIDTH-1:0]       key,
    input  logic [$clog2(DEPTH+1)-1:0]          fifo_fill,
    input  logic [$clog2(DEPTH+1)-1:0]          heap_fill,
    input  logic signed [VALUE_WIDTH-1:0]       left_stack,
    input  logic signed [VALUE_WIDTH-1:0]       left_heap,
    input  logic                                left_gt,
    input  logic signed [VALUE_WIDTH-1:0]       right_stack,
    input  logic signed [VALUE_WIDTH-1:0]       right_fifo,
    input  logic signed [VALUE_WIDTH-1:0]       right_heap,
    output logic signed [VALUE_WIDTH-1:0]       stack_val,
    output logic signed [VALUE_WIDTH-1:0]       fifo_val,
    output logic signed [VALUE_WIDTH-1:0]       heap_val,
    output logic                                gt
);
    import sqh_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic signed [VALUE_WIDTH-1:0] stack_reg, stack_next;
    logic signed [VALUE_WIDTH-1:0] fifo_reg, fifo_next;
    logic signed [VALUE_WIDTH-1:0] heap_reg, heap_next;

    // The heap row is kept sorted, largest first; flag when the key outranks this slot.
    assign gt = (IDX_C < heap_fill) && (key > heap_reg);

    // Stack shifts down on push and up on pop.
    always_comb
    begin
        stack_next = stack_reg;
        if (op.stack_push)
        begin
            stack_next = left_stack;
        end
        else if (op.stack_pop)
        begin
            stack_next = right_stack;
        end
    end

    // Queue writes at the tail slot and shifts toward the head on pop.
    always_comb
    begin
        fifo_next = fifo_reg;
        if (op.fifo_push && (IDX_C == fifo_fill))
        begin
            fifo_next = key;
        end
        else if (op.fifo_pop)
        begin
            fifo_next = right_fifo;
        end
    end

    // Sorted insert: slots behind the insertion point take their left neighbor; pop shifts toward the head.
    always_comb
    begin
        heap_next = heap_reg;
        if (op.heap_push)
        begin
            if (left_gt)
            begin
                heap_next = left_heap;
            end
            else if (gt || (IDX_C == heap_fill))
            begin
                heap_next = key;
            end
        end
        else if (op.heap_pop)
        begin
            heap_next = right_heap;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
        fifo_reg  <= fifo_next;
        heap_reg  <= heap_next;
    end

    assign stack_val = stack_reg;
    assign fifo_val  = fifo_reg;
    assign heap_val  = heap_reg;

endmodule

// ===== src/sqh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqh_ctrl
// Fill counts, alive flags, pop checks and the verdict output register.
// ----------------------------------------------------------------------------
module sqh_ctrl #(
    parameter int DEPTH       = sqh_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sqh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sqh_in_if.sink                          in_ch,
    sqh_out_if.source                       out_ch,
    input  logic signed [VALUE_WIDTH-1:0]   stack_top,
    input  logic signed [VALUE_WIDTH-1:0]   fifo_top,
    input  logic signed [VALUE_WIDTH-1:0]   heap_top,
    output sqh_pkg::sqh_op_t                op,
    output logic signed [VALUE_WIDTH-1:0]   key,
    output logic [$clog2(DEPTH+1)-1:0]      fifo_fill,
    output logic [$clog2(DEPTH+1)-1:0]      heap_fill
);
    import sqh_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [CW-1:0] stack_fill_reg, stack_fill_next;
    logic [CW-1:0] fifo_fill_reg, fifo_fill_next;
    logic [CW-1:0] heap_fill_reg, heap_fill_next;
    logic          stack_alive_reg, stack_alive_next;
    logic          fifo_alive_reg, fifo_alive_next;
    logic          heap_alive_reg, heap_alive_next;
    logic          overflow_reg, overflow_next;
    logic          out_valid_reg, out_valid_next;
    verdict_t      verdict_reg, verdict_next;
    logic [2:0]    fits_reg, fits_next;

    logic signed [63:0] wide_value;
    logic               take;
    logic               full;
    logic               stack_ok, fifo_ok, heap_ok;
    logic [1:0]         fits_cnt;

    // A new operation is taken whenever the verdict register is free or draining.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;

    // Sign-extend, then wrap to the internal value width.
    assign wide_value = 64'(in_ch.item_value);
    assign key        = wide_value[VALUE_WIDTH-1:0];

    assign full = (stack_alive_reg && stack_fill_reg == FULL)
               || (fifo_alive_reg && fifo_fill_reg == FULL)
               || (heap_alive_reg && heap_fill_reg == FULL);

    assign stack_ok = (stack_fill_reg != '0) && (stack_top == key);
    assign fifo_ok  = (fifo_fill_reg != '0) && (fifo_top == key);
    assign heap_ok  = (heap_fill_reg != '0) && (heap_top == key);

    // Strobes for the cell rows.
    always_comb
    begin
        op.stack_push = take && in_ch.cmd && !full && stack_alive_reg;
        op.fifo_push  = take && in_ch.cmd && !full && fifo_alive_reg;
        op.heap_push  = take && in_ch.cmd && !full && heap_alive_reg;
        op.stack_pop  = take && !in_ch.cmd && stack_alive_reg && stack_ok;
        op.fifo_pop   = take && !in_ch.cmd && fifo_alive_reg && fifo_ok;
        op.heap_pop   = take && !in_ch.cmd && heap_alive_reg && heap_ok;
    end

    // Counts, alive flags and the verdict on the last operation.
    always_comb
    begin
        stack_fill_next  = stack_fill_reg;
        fifo_fill_next   = fifo_fill_reg;
        heap_fill_next   = heap_fill_reg;
        stack_alive_next = stack_alive_reg;
        fifo_alive_next  = fifo_alive_reg;
        heap_alive_next  = heap_alive_reg;
        overflow_next    = overflow_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        verdict_next     = verdict_reg;
        fits_next        = fits_reg;
        fits_cnt         = '0;

        if (op.stack_push) stack_fill_next = stack_fill_reg + 1'b1;
        if (op.fifo_push)  fifo_fill_next  = fifo_fill_reg + 1'b1;
        if (op.heap_push)  heap_fill_next  = heap_fill_reg + 1'b1;
        if (op.stack_pop)  stack_fill_next = stack_fill_reg - 1'b1;
        if (op.fifo_pop)   fifo_fill_next  = fifo_fill_reg - 1'b1;
        if (op.heap_pop)   heap_fill_next  = heap_fill_reg - 1'b1;

        if (take && in_ch.cmd && full)
        begin
            overflow_next = 1'b1;
        end
        if (take && !in_ch.cmd)
        begin
            stack_alive_next = stack_alive_reg && stack_ok;
            fifo_alive_next  = fifo_alive_reg && fifo_ok;
            heap_alive_next  = heap_alive_reg && heap_ok;
        end

        if (take && in_ch.last_op)
        begin
            fits_cnt = 2'(stack_alive_next) + 2'(fifo_alive_next) + 2'(heap_alive_next);
            if (overflow_next)
                verdict_next = V_OVERFLOW;
            else if (fits_cnt == 2'd0)
                verdict_next = V_IMPOSSIBLE;
            else if (fits_cnt > 2'd1)
                verdict_next = V_NOT_SURE;
            else if (stack_alive_next)
                verdict_next = V_STACK;
            else if (fifo_alive_next)
                verdict_next = V_QUEUE;
            else
                verdict_next = V_HEAP;
            fits_next      = {stack_alive_next, fifo_alive_next, heap_alive_next};
            out_valid_next = 1'b1;

            // Start a fresh sequence.
            stack_fill_next  = '0;
            fifo_fill_next   = '0;
            heap_fill_next   = '0;
            stack_alive_next = 1'b1;
            fifo_alive_next  = 1'b1;
            heap_alive_next  = 1'b1;
            overflow_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_fill_reg  <= '0;
            fifo_fill_reg   <= '0;
            heap_fill_reg   <= '0;
            stack_alive_reg <= 1'b1;
            fifo_alive_reg  <= 1'b1;
            heap_alive_reg  <= 1'b1;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stack_fill_reg  <= stack_fill_next;
            fifo_fill_reg   <= fifo_fill_next;
            heap_fill_reg   <= heap_fill_next;
            stack_alive_reg <= stack_alive_next;
            fifo_alive_reg  <= fifo_alive_next;
            heap_alive_reg  <= heap_alive_next;
            overflow_reg    <= overflow_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        fits_reg    <= fits_next;
    end

    assign fifo_fill         = fifo_fill_reg;
    assign heap_fill         = heap_fill_reg;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.verdict    = verdict_reg;
    assign out_ch.stack_fits = fits_reg[2];
    assign out_ch.queue_fits = fits_reg[1];
    assign out_ch.heap_fits  = fits_reg[0];

endmodule

// ===== src/sqh_checker.sv =====
// ----------------------------------------------------------------------------
// sqh_checker
// Port-level checks on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module sqh_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] verdict,
    input logic       stack_fits,
    input logic       queue_fits,
    input logic       heap_fits
);
    import sqh_pkg::*;

    // A waiting verdict stays until it is transferred.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("verdict dropped while stalled");

    // A single-structure verdict comes with exactly one fit flag set.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == V_STACK || verdict == V_QUEUE || verdict == V_HEAP)
        |-> $onehot({stack_fits, queue_fits, heap_fits}))
        else $error("single verdict with wrong fit flags");

    // Impossible means no structure fits.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == V_IMPOSSIBLE |-> !stack_fits && !queue_fits && !heap_fits)
        else $error("impossible verdict with a fit flag");

    // Not sure means at least two structures fit.
    a_many: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == V_NOT_SURE |-> $countones({stack_fits, queue_fits, heap_fits}) > 1)
        else $error("not sure verdict with fewer than two fits");

endmodule

bind stack_queue_heap_trace_checker_top sqh_checker u_sqh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .verdict    (out_ch.verdict),
    .stack_fits (out_ch.stack_fits),
    .queue_fits (out_ch.queue_fits),
    .heap_fits  (out_ch.heap_fits)
);
